### hw/rtl/script_token_lexer_top_defines.svh
`ifndef SCRIPT_TOKEN_LEXER_TOP_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_TOP_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define STL_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// Condition a implies condition c in the next cycle.
`define STL_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

### hw/rtl/stl_pkg.sv
`default_nettype none

package stl_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int FIFO_DEPTH      = 4;
    localparam int PTR_W           = $clog2(FIFO_DEPTH);
    localparam int CNT_W           = $clog2(FIFO_DEPTH + 1);
    localparam int KW_COUNT        = 4;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_STR   = 3'd2;
    localparam logic [2:0] MODE_IDENT = 3'd3;
    localparam logic [2:0] MODE_EQ    = 3'd4;

    localparam logic [4:0] TK_NUMBER  = 5'd0;
    localparam logic [4:0] TK_STRING  = 5'd1;
    localparam logic [4:0] TK_IDENT   = 5'd2;
    localparam logic [4:0] TK_KEYWORD = 5'd3;
    localparam logic [4:0] TK_PLUS    = 5'd4;
    localparam logic [4:0] TK_MINUS   = 5'd5;
    localparam logic [4:0] TK_STAR    = 5'd6;
    localparam logic [4:0] TK_SLASH   = 5'd7;
    localparam logic [4:0] TK_ASSIGN  = 5'd8;
    localparam logic [4:0] TK_EQUAL   = 5'd9;
    localparam logic [4:0] TK_LPAREN  = 5'd10;
    localparam logic [4:0] TK_RPAREN  = 5'd11;
    localparam logic [4:0] TK_LBRACE  = 5'd12;
    localparam logic [4:0] TK_RBRACE  = 5'd13;
    localparam logic [4:0] TK_SEMI    = 5'd14;
    localparam logic [4:0] TK_END     = 5'd15;
    localparam logic [4:0] TK_UNKNOWN = 5'd16;

    localparam logic [1:0] KW_LET = 2'd0;

    // keyword text, zero padded to 8 characters
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"c", "o", "n", "s", "o", "l", "e", 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd5, 4'd8, 4'd7};

    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  kw;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == ".") || (c == "_");
    endfunction

    function automatic logic [4:0] op_code(input logic [7:0] c);
        logic [4:0] op;
        unique case (c)
            "+":     op = TK_PLUS;
            "-":     op = TK_MINUS;
            "*":     op = TK_STAR;
            "/":     op = TK_SLASH;
            "(":     op = TK_LPAREN;
            ")":     op = TK_RPAREN;
            "{":     op = TK_LBRACE;
            "}":     op = TK_RBRACE;
            ";":     op = TK_SEMI;
            default: op = TK_UNKNOWN;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/script_token_lexer_top.sv
// Channel  Direction  Handshake                 Payload
// in       to block   i_in_valid / o_in_ready   i_kind, i_character
// out      from block o_out_valid / i_out_ready o_token_kind, o_keyword_id,
//                                               o_token_start, o_token_length, o_last
//
// One character per cycle while the output queue has room; an item waits in the
// input register until there is room, then its 0..2 tokens enter the output queue.
// Throughput is set by the output port: one token per cycle while i_out_ready is
// high. The 4-entry output queue absorbs items that yield two tokens.
// Reset is synchronous, active low; no clearing pass. Either side may stall freely.
`default_nettype none

`include "script_token_lexer_top_defines.svh"

module script_token_lexer_top
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_character,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_token_kind,
    output logic [1:0]       o_keyword_id,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last
);

    localparam logic [OFFSET_BITS-1:0] SAT_MAX = '1;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == SAT_MAX) ? v : v + OFFSET_BITS'(1);
    endfunction

    // input register
    logic                   r_in_valid;
    logic                   r_kind;
    logic [7:0]             r_char;

    // lexer state
    logic [2:0]             r_mode,  n_mode;
    logic [OFFSET_BITS-1:0] r_pos,   n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_run,   n_run;
    logic [KW_COUNT-1:0]    r_alive, n_alive;

    // output queue
    t_result                r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_head, r_tail;
    logic [CNT_W-1:0]       r_count;

    logic                   pop, room, proc_fire;
    logic [CNT_W-1:0]       cnt_after;
    logic [1:0]             nres;

    t_result                open_res, a_res, b_res, slot0, slot1;
    logic                   a_en, b_en, rest;
    logic [KW_COUNT-1:0]    alive_ext, alive_init, kw_hit;
    logic [1:0]             kw_sel;
    logic [15:0]            pos16;

    assign pos16 = 16'(r_pos);

    assign o_out_valid    = (r_count != '0);
    assign pop            = o_out_valid && i_out_ready;
    assign cnt_after      = r_count - CNT_W'(pop);
    assign room           = (cnt_after <= CNT_W'(FIFO_DEPTH - 2));
    assign proc_fire      = r_in_valid && room;
    assign o_in_ready     = !r_in_valid || proc_fire;

    assign o_token_kind   = r_fifo[r_head].kind;
    assign o_keyword_id   = r_fifo[r_head].kw;
    assign o_token_start  = r_fifo[r_head].start;
    assign o_token_length = r_fifo[r_head].len;
    assign o_last         = r_fifo[r_head].last;

    // keyword prefix tracking
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            alive_ext[k]  = r_alive[k] && (r_run < OFFSET_BITS'(KW_LEN[k]))
                            && (KW_TEXT[k][r_run[2:0]] == r_char);
            alive_init[k] = (KW_TEXT[k][0] == r_char);
            kw_hit[k]     = r_alive[k] && (r_run == OFFSET_BITS'(KW_LEN[k]));
        end
        kw_sel = KW_LET;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                kw_sel = 2'(k);
            end
        end
    end

    // token that closes the open run
    always_comb begin
        open_res       = '0;
        open_res.start = 16'(r_start);
        open_res.len   = 16'(r_run);
        unique case (r_mode)
            MODE_NUM:   open_res.kind = TK_NUMBER;
            MODE_STR:   open_res.kind = TK_STRING;
            MODE_IDENT: begin
                if (kw_hit != '0) begin
                    open_res.kind = TK_KEYWORD;
                    open_res.kw   = kw_sel;
                end else begin
                    open_res.kind = TK_IDENT;
                end
            end
            MODE_EQ: begin
                open_res.kind = TK_ASSIGN;
                open_res.len  = 16'd1;
            end
            default:    open_res.kind = TK_UNKNOWN;
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_run   = r_run;
        n_alive = r_alive;
        a_en    = 1'b0;
        a_res   = open_res;
        b_en    = 1'b0;
        b_res   = '0;
        rest    = 1'b0;
        if (r_kind) begin
            a_en       = (r_mode != MODE_IDLE);
            b_en       = 1'b1;
            b_res.kind = TK_END;
            b_res.start = pos16;
            n_mode     = MODE_IDLE;
            n_pos      = '0;
            n_start    = '0;
            n_run      = '0;
            n_alive    = '1;
        end else begin
            unique case (r_mode)
                MODE_NUM: begin
                    if (is_digit(r_char)) begin
                        n_run = sat_inc(r_run);
                    end else begin
                        a_en   = 1'b1;
                        n_mode = MODE_IDLE;
                        rest   = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (r_char == "\"") begin
                        a_en   = 1'b1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_run = sat_inc(r_run);
                    end
                end
                MODE_IDENT: begin
                    if (is_ident_char(r_char)) begin
                        n_alive = alive_ext;
                        n_run   = sat_inc(r_run);
                    end else begin
                        a_en   = 1'b1;
                        n_mode = MODE_IDLE;
                        rest   = 1'b1;
                    end
                end
                MODE_EQ: begin
                    a_en   = 1'b1;
                    n_mode = MODE_IDLE;
                    if (r_char == "=") begin
                        a_res.kind = TK_EQUAL;
                        a_res.len  = 16'd2;
                    end else begin
                        rest = 1'b1;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    rest   = 1'b1;
                end
            endcase
            if (rest) begin
                if (is_space(r_char)) begin
                    // separator only
                end else if (is_digit(r_char)) begin
                    n_mode  = MODE_NUM;
                    n_start = r_pos;
                    n_run   = OFFSET_BITS'(1);
                end else if (r_char == "\"") begin
                    n_mode  = MODE_STR;
                    n_start = sat_inc(r_pos);
                    n_run   = '0;
                end else if (is_alpha(r_char) || (r_char == "_")) begin
                    n_mode  = MODE_IDENT;
                    n_start = r_pos;
                    n_run   = OFFSET_BITS'(1);
                    n_alive = alive_init;
                end else if (r_char == "=") begin
                    n_mode  = MODE_EQ;
                    n_start = r_pos;
                end else begin
                    b_en        = 1'b1;
                    b_res.kind  = op_code(r_char);
                    b_res.start = pos16;
                    b_res.len   = 16'd1;
                end
            end
            n_pos = sat_inc(r_pos);
        end
    end

    always_comb begin
        nres       = proc_fire ? (2'(a_en) + 2'(b_en)) : 2'd0;
        slot0      = a_en ? a_res : b_res;
        slot0.last = !(a_en && b_en);
        slot1      = b_res;
        slot1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_pos      <= '0;
            r_start    <= '0;
            r_run      <= '0;
            r_alive    <= '1;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (proc_fire) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_run   <= n_run;
                r_alive <= n_alive;
            end
            r_head  <= r_head + PTR_W'(pop);
            r_tail  <= r_tail + PTR_W'(nres);
            r_count <= cnt_after + CNT_W'(nres);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_char <= i_character;
        end
        if (nres != 2'd0) begin
            r_fifo[r_tail] <= slot0;
        end
        if (nres == 2'd2) begin
            r_fifo[r_tail + PTR_W'(1)] <= slot1;
        end
    end

    `STL_ASSERT_NOW(a_end_token_last, o_out_valid && (o_token_kind == TK_END), o_last && (o_token_length == 16'd0), "END token must be last and empty")
    `STL_ASSERT_NEXT(a_end_restarts, proc_fire && r_kind, (r_pos == '0) && (r_mode == MODE_IDLE), "end of source must restart the lexer")
    `STL_ASSERT_NOW(a_run_nonzero, (r_mode == MODE_NUM) || (r_mode == MODE_IDENT), r_run != '0, "open number or identifier with zero length")
    `STL_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= CNT_W'(FIFO_DEPTH), "output queue overfilled")

endmodule

`default_nettype wire

### sim/script_token_lexer_top_test.sv
`default_nettype none

module script_token_lexer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    localparam logic IN_CHAR     = 1'b0;
    localparam logic IN_END      = 1'b1;
    localparam int   STALL_LIMIT = 2000;
    localparam int   RAND_ITEMS  = 1680;
    localparam int   QUIET_TAIL  = 300;
    localparam int   STR_CHARS   = 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_src_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic        typed;
        logic [4:0]  tk;
        logic [15:0] st;
        logic [15:0] ln;
    } t_dir_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_kind         = IN_CHAR;
    logic [7:0]  i_character    = 8'h00;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [4:0]  o_token_kind;
    logic [1:0]  o_keyword_id;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_last;

    // lexer state mirror
    logic [2:0]  lx_mode   = MODE_IDLE;
    logic [15:0] pos       = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_len   = '0;
    logic [3:0]  kw_live   = '1;

    string     kw_word [4] = '{"let", "const", "function", "console"};
    string     word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._";
    string     op_chars    = "+-*/(){};";
    t_result   step_tokens [$];
    t_result   pending_tokens [$];
    t_src_item src_q [$];
    int        err_cnt      = 0;
    int        stall_cycles = 0;
    bit        quiet        = 1'b0;

    // typed rows carry their token; the rest go through the predictor
    t_dir_row dir_rows [25] = '{
        '{IN_CHAR, "+",   1'b1, TK_PLUS,    16'd0,  16'd1},
        '{IN_CHAR, "-",   1'b1, TK_MINUS,   16'd1,  16'd1},
        '{IN_CHAR, "*",   1'b1, TK_STAR,    16'd2,  16'd1},
        '{IN_CHAR, "/",   1'b1, TK_SLASH,   16'd3,  16'd1},
        '{IN_CHAR, "(",   1'b1, TK_LPAREN,  16'd4,  16'd1},
        '{IN_CHAR, ")",   1'b1, TK_RPAREN,  16'd5,  16'd1},
        '{IN_CHAR, "{",   1'b1, TK_LBRACE,  16'd6,  16'd1},
        '{IN_CHAR, "}",   1'b1, TK_RBRACE,  16'd7,  16'd1},
        '{IN_CHAR, ";",   1'b1, TK_SEMI,    16'd8,  16'd1},
        '{IN_CHAR, 8'hFF, 1'b1, TK_UNKNOWN, 16'd9,  16'd1},
        '{IN_CHAR, 8'h00, 1'b1, TK_UNKNOWN, 16'd10, 16'd1},
        '{IN_CHAR, "=",   1'b0, '0, '0, '0},
        '{IN_CHAR, "=",   1'b0, '0, '0, '0},
        '{IN_CHAR, "l",   1'b0, '0, '0, '0},
        '{IN_CHAR, "e",   1'b0, '0, '0, '0},
        '{IN_CHAR, "t",   1'b0, '0, '0, '0},
        '{IN_CHAR, "=",   1'b0, '0, '0, '0},
        '{IN_CHAR, "9",   1'b0, '0, '0, '0},
        '{IN_CHAR, "0",   1'b0, '0, '0, '0},
        '{IN_CHAR, "\"",  1'b0, '0, '0, '0},
        '{IN_CHAR, "a",   1'b0, '0, '0, '0},
        '{IN_END,  8'hA5, 1'b0, '0, '0, '0},
        '{IN_END,  8'h5A, 1'b1, TK_END,     16'd0,  16'd0},
        '{IN_CHAR, "=",   1'b0, '0, '0, '0},
        '{IN_END,  8'hFF, 1'b0, '0, '0, '0}
    };

    script_token_lexer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_character    (i_character),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_keyword_id   (o_keyword_id),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_let(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic void put_tok(input logic [4:0] kind, input logic [1:0] kw,
                                    input logic [15:0] start, input logic [15:0] len);
        t_result r;
        r.kind  = kind;
        r.kw    = kw;
        r.start = start;
        r.len   = len;
        r.last  = 1'b0;
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    function automatic void kw_step(input logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (int'(tok_len) >= kw_word[k].len() || kw_word[k][tok_len] != c)
                kw_live[k] = 1'b0;
        end
        tok_len = sat_inc(tok_len);
    endfunction

    function automatic void flush_open();
        bit hit;
        hit = 1'b0;
        case (lx_mode)
            MODE_NUM: put_tok(TK_NUMBER, KW_LET, tok_start, tok_len);
            MODE_STR: put_tok(TK_STRING, KW_LET, tok_start, tok_len);
            MODE_IDENT: begin
                for (int k = 0; k < 4; k++) begin
                    if (!hit && kw_live[k] && int'(tok_len) == kw_word[k].len()) begin
                        put_tok(TK_KEYWORD, k[1:0], tok_start, tok_len);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    put_tok(TK_IDENT, KW_LET, tok_start, tok_len);
            end
            MODE_EQ: put_tok(TK_ASSIGN, KW_LET, tok_start, 16'd1);
            default: ;
        endcase
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void lex_step(input logic kind, input logic [7:0] c);
        bit         fresh;
        logic [4:0] op;
        step_tokens.delete();
        if (kind == IN_END) begin
            flush_open();
            put_tok(TK_END, KW_LET, pos, 16'd0);
            lx_mode   = MODE_IDLE;
            pos       = '0;
            tok_start = '0;
            tok_len   = '0;
            kw_live   = '1;
        end else begin
            fresh = 1'b1;
            case (lx_mode)
                MODE_NUM: begin
                    if (is_dig(c)) begin
                        tok_len = sat_inc(tok_len);
                        fresh   = 1'b0;
                    end else begin
                        flush_open();
                    end
                end
                MODE_STR: begin
                    if (c == "\"")
                        flush_open();
                    else
                        tok_len = sat_inc(tok_len);
                    fresh = 1'b0;
                end
                MODE_IDENT: begin
                    if (is_let(c) || is_dig(c) || c == "." || c == "_") begin
                        kw_step(c);
                        fresh = 1'b0;
                    end else begin
                        flush_open();
                    end
                end
                MODE_EQ: begin
                    if (c == "=") begin
                        put_tok(TK_EQUAL, KW_LET, tok_start, 16'd2);
                        lx_mode = MODE_IDLE;
                        fresh   = 1'b0;
                    end else begin
                        flush_open();
                    end
                end
                default: lx_mode = MODE_IDLE;
            endcase
            if (fresh && !(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                if (is_dig(c)) begin
                    lx_mode   = MODE_NUM;
                    tok_start = pos;
                    tok_len   = 16'd1;
                end else if (c == "\"") begin
                    lx_mode   = MODE_STR;
                    tok_start = sat_inc(pos);
                    tok_len   = '0;
                end else if (is_let(c) || c == "_") begin
                    lx_mode   = MODE_IDENT;
                    tok_start = pos;
                    tok_len   = '0;
                    kw_live   = '1;
                    kw_step(c);
                end else if (c == "=") begin
                    lx_mode   = MODE_EQ;
                    tok_start = pos;
                end else begin
                    case (c)
                        "+":     op = TK_PLUS;
                        "-":     op = TK_MINUS;
                        "*":     op = TK_STAR;
                        "/":     op = TK_SLASH;
                        "(":     op = TK_LPAREN;
                        ")":     op = TK_RPAREN;
                        "{":     op = TK_LBRACE;
                        "}":     op = TK_RBRACE;
                        ";":     op = TK_SEMI;
                        default: op = TK_UNKNOWN;
                    endcase
                    put_tok(op, KW_LET, pos, 16'd1);
                end
            end
            pos = sat_inc(pos);
        end
        if (step_tokens.size() != 0)
            step_tokens[$].last = 1'b1;
    endfunction

    function automatic void push_ch(input logic [7:0] c);
        src_q.insert(src_q.size(), '{IN_CHAR, c});
    endfunction

    task automatic drive_item(input logic kind, input logic [7:0] ch, input logic typed,
                              input t_result typed_tok);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_character <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        lex_step(kind, ch);
        if (typed) begin
            step_tokens.delete();
            step_tokens.insert(0, typed_tok);
        end
        foreach (step_tokens[j])
            pending_tokens.insert(pending_tokens.size(), step_tokens[j]);
    endtask

    // output side: random stall bursts
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : token_check
        t_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind  = o_token_kind;
            got.kw    = o_keyword_id;
            got.start = o_token_start;
            got.len   = o_token_length;
            got.last  = o_last;
            if (pending_tokens.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected token: kind %0d kw %0d start %0d len %0d last %0d",
                             got.kind, got.kw, got.start, got.len, got.last);
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 want.kind, want.kw, want.start, want.len, want.last,
                                 got.kind, got.kw, got.start, got.len, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_result     tok;
        logic [7:0]  c;
        string       w;
        int          n, idx, last_i;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            tok.kind  = dir_rows[i].tk;
            tok.kw    = KW_LET;
            tok.start = dir_rows[i].st;
            tok.len   = dir_rows[i].ln;
            tok.last  = 1'b1;
            drive_item(dir_rows[i].kind, dir_rows[i].ch, dir_rows[i].typed, tok);
        end

        // hold input until the output side has drained
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);

        // string of random bytes, closed, then a few short tokens
        drive_item(IN_CHAR, "\"", 1'b0, '0);
        for (int i = 0; i < STR_CHARS; i++) begin
            do c = 8'($urandom_range(0, 255)); while (c == "\"");
            drive_item(IN_CHAR, c, 1'b0, '0);
        end
        drive_item(IN_CHAR, "\"", 1'b0, '0);
        drive_item(IN_CHAR, "a", 1'b0, '0);
        drive_item(IN_CHAR, "+", 1'b0, '0);
        drive_item(IN_CHAR, "7", 1'b0, '0);
        drive_item(IN_CHAR, "=", 1'b0, '0);
        drive_item(IN_END, 8'h00, 1'b0, '0);

        while (src_q.size() < RAND_ITEMS) begin
            n = $urandom_range(0, 99);
            if (n < 16) begin
                w = kw_word[$urandom_range(0, 3)];
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w.len()) : w.len();
                for (int k = 0; k < idx; k++) push_ch(w[k]);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        push_ch(word_chars[$urandom_range(0, 63)]);
            end else if (n < 30) begin
                idx = $urandom_range(0, 52);
                push_ch(word_chars[(idx == 52) ? 63 : idx]);
                repeat ($urandom_range(0, 7)) push_ch(word_chars[$urandom_range(0, 63)]);
            end else if (n < 40) begin
                repeat ($urandom_range(1, 6)) push_ch(8'("0" + $urandom_range(0, 9)));
            end else if (n < 50) begin
                push_ch("\"");
                repeat ($urandom_range(0, 8)) begin
                    do c = 8'($urandom_range(0, 255)); while (c == "\"");
                    push_ch(c);
                end
                if ($urandom_range(0, 9) != 0) push_ch("\"");
            end else if (n < 65) begin
                push_ch(op_chars[$urandom_range(0, 8)]);
            end else if (n < 73) begin
                push_ch("=");
                if ($urandom_range(0, 1)) push_ch("=");
            end else if (n < 85) begin
                repeat ($urandom_range(1, 3))
                    push_ch($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
            end else if (n < 97) begin
                push_ch(8'($urandom_range(0, 255)));
            end else begin
                src_q.insert(src_q.size(), '{IN_END, 8'($urandom_range(0, 255))});
            end
            if ($urandom_range(0, 1))
                push_ch($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        end
        src_q.insert(src_q.size(), '{IN_END, 8'($urandom_range(0, 255))});

        last_i = src_q.size() - QUIET_TAIL;
        foreach (src_q[i]) begin
            quiet = (i >= last_i);
            drive_item(src_q[i].kind, src_q[i].ch, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/stl_pkg.sv
hw/rtl/script_token_lexer_top.sv
sim/script_token_lexer_top_test.sv
